[hw/rtl/ovle_pkg.sv]
// Shared constants and codes of the ordered value list engine.
`default_nettype none

package ovle_pkg;

  // List geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Fixed field widths of the channels
  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;
  localparam int STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_FRONT  = 2'd1,
    OP_FIND   = 2'd2,
    OP_DELETE = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

endpackage

`default_nettype wire

[hw/rtl/ovle_if.sv]
// Request and response channel interfaces of the ordered value list engine.
`default_nettype none

interface ovle_in_if;
  import ovle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface ovle_out_if;
  import ovle_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  logic [LEN_W-1:0]  length;
  logic [STAT_W-1:0] status;

  modport source (output valid, output position, output length, output status, input ready);
  modport sink   (input valid, input position, input length, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/ovle_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ovle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/ordered_value_list_engine.sv]
// Ordered value list engine: circular list store, search and delete sequencer.
// Find and delete walk the list from the head to a match or the end of the list; delete
//   then moves each entry behind the match one place toward the head.
// Throughput: one item at a time, the next accepted in the same cycle as the result issues;
//   one comparator walks one entry a cycle.
// Reset: the list is empty and the head pointer is zero; the RAM is not cleared.
`default_nettype none

module ordered_value_list_engine (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ovle_in_if.sink      req_i,
  ovle_out_if.source   rsp_o
);
  import ovle_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  localparam int SUM_W = CNT_W + 1;

  // Map a list position to a RAM address, wrapping once around the ring
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] logical);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(logical);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [2:0]        state_q, state_d;
  opcode_e           op_q, op_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  res_pos_q, res_pos_d;
  status_e           res_status_q, res_status_d;

  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  status_e           out_status_q, out_status_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              req_accept;
  logic              rsp_take;
  logic              list_full;
  logic [CNT_W-1:0]  idx_next;
  logic [CNT_W-1:0]  idx_next2;

  assign list_full  = (count_q == CNT_W'(CAPACITY));
  assign idx_next   = CNT_W'(idx_q) + CNT_W'(1);
  assign idx_next2  = CNT_W'(idx_q) + CNT_W'(2);
  assign req_accept = req_i.valid && (state_q == S_IDLE);
  assign rsp_take   = out_valid_q && rsp_o.ready;

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.position = out_pos_q;
  assign rsp_o.length   = out_len_q;
  assign rsp_o.status   = out_status_q;

  // Entry store
  ovle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: execute, scan one entry a cycle, close the gap, respond
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    value_d      = value_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    res_pos_d    = res_pos_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_pos_d    = out_pos_q;
    out_len_d    = out_len_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = phys_addr(head_q, count_q);
    ram_wdata    = value_q;
    ram_raddr    = phys_addr(head_q, idx_next);

    // Drop the held result once taken
    if (rsp_take) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          op_d    = opcode_e'(req_i.opcode);
          value_d = req_i.value;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_pos_d    = '0;
        res_status_d = ST_OK;
        idx_d        = '0;
        state_d      = S_RESP;
        case (op_q)
          OP_APPEND: begin
            if (list_full) begin
              res_status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = phys_addr(head_q, count_q);
              count_d   = count_q + CNT_W'(1);
            end
          end
          OP_FRONT: begin
            if (list_full) begin
              res_status_d = ST_FULL;
            end else begin
              if (head_q == '0) begin
                head_d = IDX_W'(CAPACITY - 1);
              end else begin
                head_d = head_q - IDX_W'(1);
              end
              ram_we    = 1'b1;
              ram_waddr = head_d;
              count_d   = count_q + CNT_W'(1);
            end
          end
          OP_FIND, OP_DELETE: begin
            if (count_q == '0) begin
              res_status_d = ST_NOTFOUND;
            end else begin
              ram_raddr = phys_addr(head_q, '0);
              state_d   = S_SCAN;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        // Data of entry idx_q arrives; fetch the next one meanwhile
        ram_raddr = phys_addr(head_q, idx_next);
        if (ram_rdata == value_q) begin
          if (op_q == OP_FIND) begin
            res_pos_d = idx_next;
            state_d   = S_RESP;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (idx_next >= count_q) begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          idx_d = idx_next[IDX_W-1:0];
        end
      end
      S_SHIFT: begin
        // Move entry idx_q+1 into idx_q until the tail is reached
        if (idx_next < count_q) begin
          ram_we    = 1'b1;
          ram_waddr = phys_addr(head_q, CNT_W'(idx_q));
          ram_wdata = ram_rdata;
          ram_raddr = phys_addr(head_q, idx_next2);
          idx_d     = idx_next[IDX_W-1:0];
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_pos_d    = POS_W'(res_pos_q);
          out_len_d    = LEN_W'(count_q);
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    value_q      <= value_d;
    idx_q        <= idx_d;
    res_pos_q    <= res_pos_d;
    res_status_q <= res_status_d;
    out_pos_q    <= out_pos_d;
    out_len_q    <= out_len_d;
    out_status_q <= out_status_d;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EXEC || state_q == S_SHIFT))
    else $error("RAM written outside execute or shift");

  a_walk_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SHIFT) |-> (CNT_W'(idx_q) < count_q))
    else $error("walk index beyond list end");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> (state_q == S_EXEC))
    else $error("accepted item not executed");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_SHIFT))
    else $error("list length changed outside execute or shift");

endmodule

`default_nettype wire
